/* sv/banked_rom_mapper_scanline_irq_macros.svh */
// Assertion macros for the banked ROM mapper checker.
`ifndef BANKED_ROM_MAPPER_SCANLINE_IRQ_MACROS_SVH
`define BANKED_ROM_MAPPER_SCANLINE_IRQ_MACROS_SVH
// Assert that a condition implies a consequent in the same cycle.
`define BRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequent in the next cycle.
`define BRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/brm_pkg.sv */
// Shared types, codes and constants of the banked ROM mapper.
package brm_pkg;
  localparam int unsigned PageW = 6;
  localparam logic [PageW-1:0] PrgPagesRst = 6'd2;
  localparam logic [PageW-1:0] ChrPagesRst = 6'd1;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_CPU_RD = 3'd0, OP_CPU_WR = 3'd1, OP_CHR_RD = 3'd2,
    OP_CHR_WR = 3'd3, OP_NT_RD = 3'd4, OP_NT_WR = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0, TGT_PRG_RAM = 3'd1, TGT_PRG_ROM = 3'd2,
    TGT_CHR_ROM = 3'd3, TGT_NT_RAM = 3'd4
  } tgt_t;

  localparam logic CFG_PRG_PAGES = 1'b0;
  localparam logic CFG_CHR_PAGES = 1'b1;

  // Classified item from the front part. For a banked access, sel is the raw bank
  // number and offset the in-bank address; the back part reduces sel mod banks.
  typedef struct packed {
    tgt_t        target;
    logic        is_chr;
    logic [7:0]  sel;
    logic [18:0] offset;
    logic        mem_write;
    logic [7:0]  mem_data;
    logic        irq_line;
  } cmd_t;
endpackage

/* sv/brm_front.sv */
// Front part: register file, IRQ counter and classification of each access.
module brm_front import brm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic [6:0]  prg_banks,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  logic [7:0] bank_control_r;
  logic [7:0] bank_table_r [8];
  logic       hmirror_r;
  logic [7:0] latch_r;
  logic       reload_r;
  logic       irq_en_r;
  logic       prev_a12_r;
  logic       irq_held_r;
  logic [7:0] count_r;

  logic       acc;
  logic [15:0] a;
  logic       vid;
  logic       a12;
  logic       edge_up;
  logic [7:0] count_nxt;
  logic       irq_set;
  logic [2:0] which;
  logic [1:0] pslot;
  logic       pmode;
  logic [2:0] cslot;
  logic [7:0] csel;
  logic [7:0] psel;
  logic [6:0] bm1;
  logic [6:0] bm2;

  assign in_stall = !cmd_ready;
  assign acc = in_valid && cmd_ready;
  assign a = in_bus_address;
  assign vid = (in_opcode == OP_CHR_RD) || (in_opcode == OP_CHR_WR) ||
               (in_opcode == OP_NT_RD) || (in_opcode == OP_NT_WR);
  assign a12 = a[12];
  assign edge_up = vid && a12 && !prev_a12_r;
  assign count_nxt = (reload_r || count_r == 8'd0) ? latch_r : count_r - 8'd1;
  assign irq_set = edge_up && count_nxt == 8'd0 && irq_en_r;
  assign which = {a[14:13], a[0]};
  assign bm1 = prg_banks - 7'd1;
  assign bm2 = prg_banks - 7'd2;
  assign pslot = a[14:13];
  assign pmode = bank_control_r[6];
  assign cslot = a[12:10] ^ {bank_control_r[7], 2'b00};

  always_comb begin
    case (pslot)
      2'd0:    psel = pmode ? {1'b0, bm2} : bank_table_r[6];
      2'd1:    psel = bank_table_r[7];
      2'd2:    psel = pmode ? bank_table_r[6] : {1'b0, bm2};
      default: psel = {1'b0, bm1};
    endcase
    if (!cslot[2]) begin
      csel = cslot[0] ? (bank_table_r[{2'b00, cslot[1]}] | 8'h01)
                      : (bank_table_r[{2'b00, cslot[1]}] & 8'hFE);
    end else begin
      csel = bank_table_r[cslot - 3'd2];
    end
  end

  always_comb begin
    cmd = '0;
    cmd.irq_line = irq_held_r;
    case (in_opcode)
      OP_CPU_RD, OP_CPU_WR: begin
        if (a[15:13] == 3'b011) begin
          cmd.target = TGT_PRG_RAM;
          cmd.offset = {6'd0, a[12:0]};
          cmd.mem_write = (in_opcode == OP_CPU_WR);
        end else if (a[15] && in_opcode == OP_CPU_RD) begin
          cmd.target = TGT_PRG_ROM;
          cmd.sel = psel;
          cmd.offset = {6'd0, a[12:0]};
        end
      end
      OP_CHR_RD: begin
        cmd.target = TGT_CHR_ROM;
        cmd.is_chr = 1'b1;
        cmd.sel = csel;
        cmd.offset = {9'd0, a[9:0]};
      end
      OP_NT_RD, OP_NT_WR: begin
        cmd.target = TGT_NT_RAM;
        cmd.offset = hmirror_r ? {8'd0, a[11], a[9:0]} : {8'd0, a[10:0]};
        cmd.mem_write = (in_opcode == OP_NT_WR);
      end
      default: cmd.target = TGT_NONE;
    endcase
    if (cmd.mem_write) cmd.mem_data = in_write_byte;
    if (acc && vid) begin
      if (irq_set) cmd.irq_line = 1'b1;
    end
    if (acc && in_opcode == OP_CPU_WR && a[15]) begin
      if (which == 3'd6) cmd.irq_line = 1'b0;
    end
  end

  assign cmd_valid = in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_control_r <= '0;
      for (int i = 0; i < 8; i++) bank_table_r[i] <= '0;
      hmirror_r <= 1'b0;
      latch_r <= '0;
      reload_r <= 1'b0;
      irq_en_r <= 1'b0;
      prev_a12_r <= 1'b0;
      irq_held_r <= 1'b0;
      count_r <= '0;
    end else if (acc) begin
      if (vid) begin
        prev_a12_r <= a12;
        if (edge_up) begin
          count_r <= count_nxt;
          reload_r <= 1'b0;
          if (irq_set) irq_held_r <= 1'b1;
        end
      end
      if (in_opcode == OP_CPU_WR && a[15]) begin
        case (which)
          3'd0: bank_control_r <= in_write_byte;
          3'd1: bank_table_r[bank_control_r[2:0]] <= in_write_byte;
          3'd2: hmirror_r <= in_write_byte[0];
          3'd4: latch_r <= in_write_byte;
          3'd5: reload_r <= 1'b1;
          3'd6: begin
            irq_en_r <= 1'b0;
            irq_held_r <= 1'b0;
          end
          3'd7: irq_en_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end
endmodule

/* sv/brm_queue.sv */
// Short FIFO of classified items between the front and back parts.
module brm_queue import brm_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  cmd_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

/* sv/brm_back.sv */
// Back part: serial bank modulo and output register.
module brm_back import brm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  input  logic [6:0]  prg_banks,
  input  logic [8:0]  chr_banks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_target,
  output logic [18:0] out_mem_address,
  output logic        out_mem_write,
  output logic [7:0]  out_mem_data,
  output logic        out_irq_line
);
  typedef enum logic [1:0] {S_IDLE, S_MOD, S_OUT} state_t;
  state_t state_r;
  cmd_t   cmd_r;
  logic [8:0] rem_r;
  logic [8:0] div_r;
  logic [2:0] step_r;
  logic [8:0] trial;
  logic [8:0] shifted;
  logic [18:0] addr;

  // Restoring modulo: one shifted divisor compare per cycle, 7 down to 0.
  assign shifted = div_r << step_r;
  assign trial = rem_r - shifted;
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    addr = '0;
    case (cmd_r.target)
      TGT_PRG_ROM: addr = {rem_r[5:0], cmd_r.offset[12:0]};
      TGT_CHR_ROM: addr = {rem_r[8:0], cmd_r.offset[9:0]};
      default:     addr = cmd_r.offset;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (!q_empty) begin
          cmd_r <= q_head;
          rem_r <= {1'b0, q_head.sel};
          div_r <= q_head.is_chr ? chr_banks : {2'b00, prg_banks};
          step_r <= 3'd7;
          state_r <= (q_head.target == TGT_PRG_ROM || q_head.target == TGT_CHR_ROM)
                     ? S_MOD : S_OUT;
        end
        S_MOD: begin
          if ({3'b000, rem_r} >= ({3'b000, div_r} << step_r)) rem_r <= trial;
          if (step_r == 3'd0) state_r <= S_OUT;
          else step_r <= step_r - 3'd1;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_target <= cmd_r.target;
          out_mem_address <= addr;
          out_mem_write <= cmd_r.mem_write;
          out_mem_data <= cmd_r.mem_data;
          out_irq_line <= cmd_r.irq_line;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      if (state_r == S_OUT && out_valid && out_stall) out_valid <= 1'b1;
    end
  end
endmodule

/* sv/banked_rom_mapper_scanline_irq.sv */
// Banked ROM mapper with scanline IRQ: one result item per access item. The front
// part decodes each access and updates registers in the cycle it is taken; a
// two-entry queue feeds the back part, which reduces the bank number modulo the
// bank count with a serial restoring step per cycle. In the back part a banked
// ROM access passes through taking the item, eight modulo steps and loading the
// output register, while any other access skips the modulo steps; the front
// takes a new item each cycle while the queue has room.
module banked_rom_mapper_scanline_irq import brm_pkg::*; #(
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_target,
  output logic [18:0] out_mem_address,
  output logic        out_mem_write,
  output logic [7:0]  out_mem_data,
  output logic        out_irq_line,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  logic [PageW-1:0] prg_pages_r, chr_pages_r;
  logic [5:0] prg_cl, chr_cl;
  logic [6:0] prg_banks;
  logic [8:0] chr_banks;
  logic cmd_valid, q_full, q_empty, q_pop;
  cmd_t cmd, q_head;

  assign cfg_ready = 1'b1;
  assign prg_cl = (prg_pages_r == '0) ? 6'd1 : (prg_pages_r > 6'd32 ? 6'd32 : prg_pages_r);
  assign chr_cl = (chr_pages_r == '0) ? 6'd1 : (chr_pages_r > 6'd32 ? 6'd32 : chr_pages_r);
  assign prg_banks = {prg_cl, 1'b0};
  assign chr_banks = {chr_cl, 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_pages_r <= PrgPagesRst;
      chr_pages_r <= ChrPagesRst;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PRG_PAGES) prg_pages_r <= cfg_data;
      else chr_pages_r <= cfg_data;
    end
  end

  brm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_bus_address, .in_write_byte,
    .prg_banks, .cmd_valid, .cmd_ready(!q_full), .cmd
  );

  brm_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .push(cmd_valid), .push_data(cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  brm_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .prg_banks, .chr_banks,
    .out_valid, .out_stall, .out_target, .out_mem_address, .out_mem_write,
    .out_mem_data, .out_irq_line
  );
endmodule

/* sv/brm_checker.sv */
// Port-level checker for the banked ROM mapper, bound to the top level.
`include "banked_rom_mapper_scanline_irq_macros.svh"
module brm_checker import brm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_target,
  input logic [18:0] out_mem_address,
  input logic        out_mem_write,
  input logic [7:0]  out_mem_data
);
  `BRM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `BRM_ASSERT_IMP(a_none_addr, out_valid && out_target == TGT_NONE, out_mem_address == 19'd0)
  `BRM_ASSERT_IMP(a_data_zero, out_valid && !out_mem_write, out_mem_data == 8'd0)
  `BRM_ASSERT_IMP(a_nt_range, out_valid && out_target == TGT_NT_RAM, out_mem_address < 19'h800)
endmodule

bind banked_rom_mapper_scanline_irq brm_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_target, .out_mem_address,
  .out_mem_write, .out_mem_data
);
